@@ src/qrs_pkg.sv @@
package qrs_pkg;

  // width of each root on the result port
  localparam int unsigned ROOT_W = 34;
  localparam int unsigned KIND_W = 3;

  // result classification as seen on the port
  typedef enum logic [KIND_W-1:0] {
    KIND_TWO    = 3'd0,
    KIND_ONE    = 3'd1,
    KIND_DOUBLE = 3'd2,
    KIND_NONE   = 3'd3,
    KIND_ALL    = 3'd4
  } qrs_kind_e;

  // how the back end turns sqrt and division results into roots
  typedef enum logic [2:0] {
    OP_ZERO,    // both roots zero
    OP_QUAD,    // (-b -/+ sqrt d) / 2a
    OP_DOUBLE,  // -b / 2a twice
    OP_LIN,     // -c / b
    OP_SQRT,    // +/- sqrt(|a||c|) / |a|
    OP_CZERO    // -b / a and zero
  } qrs_op_e;

  typedef struct packed {
    qrs_op_e   op;
    qrs_kind_e kind;
  } qrs_ctl_t;

endpackage

@@ src/qrs_fifo.sv @@
module qrs_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

@@ src/qrs_front.sv @@
module qrs_front #(
  parameter int unsigned CW  = 16,
  parameter int unsigned F   = 16,
  parameter int unsigned VW  = 33,
  parameter int unsigned NSW = 35,
  parameter int unsigned DW  = 17
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [CW-1:0]  coef_a_i,
  input  logic signed [CW-1:0]  coef_b_i,
  input  logic signed [CW-1:0]  coef_c_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output qrs_pkg::qrs_ctl_t     ctl_o,
  output logic [VW-1:0]         rad_o,
  output logic signed [NSW-1:0] nb_o,
  output logic [DW-1:0]         den_o,
  output logic                  den_neg_o
);

  localparam int unsigned PW = 2 * CW;
  localparam int unsigned XW = 2 * CW + 2;

  logic                 valid_q;
  logic signed [CW-1:0] a_q, b_q, c_q;
  logic signed [PW-1:0] bb_q, ac_q;

  logic signed [XW-1:0] disc;
  logic                 az, bz, cz;
  logic [DW-1:0]        amag, bmag;
  logic signed [DW-1:0] a_ext, b_ext;
  logic signed [NSW-1:0] nb_b, nb_c;

  assign in_ready_o   = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_q  <= coef_a_i;
      b_q  <= coef_b_i;
      c_q  <= coef_c_i;
      bb_q <= PW'(coef_b_i) * PW'(coef_b_i);
      ac_q <= PW'(coef_a_i) * PW'(coef_c_i);
    end
  end

  assign disc  = XW'(bb_q) - (XW'(ac_q) <<< 2);
  assign az    = (a_q == '0);
  assign bz    = (b_q == '0);
  assign cz    = (c_q == '0);
  assign a_ext = DW'(a_q);
  assign b_ext = DW'(b_q);
  assign amag  = a_q[CW-1] ? DW'(-a_ext) : DW'(a_ext);
  assign bmag  = b_q[CW-1] ? DW'(-b_ext) : DW'(b_ext);
  assign nb_b  = -(NSW'(b_q) <<< F);
  assign nb_c  = -(NSW'(c_q) <<< F);

  // classification
  always_comb begin
    ctl_o.op   = qrs_pkg::OP_ZERO;
    ctl_o.kind = qrs_pkg::KIND_ALL;
    if (!az && !bz && !cz) begin
      if (disc > 0) begin
        ctl_o.op   = qrs_pkg::OP_QUAD;
        ctl_o.kind = qrs_pkg::KIND_TWO;
      end else if (disc == 0) begin
        ctl_o.op   = qrs_pkg::OP_DOUBLE;
        ctl_o.kind = qrs_pkg::KIND_DOUBLE;
      end else begin
        ctl_o.kind = qrs_pkg::KIND_NONE;
      end
    end else if (az && !bz && !cz) begin
      ctl_o.op   = qrs_pkg::OP_LIN;
      ctl_o.kind = qrs_pkg::KIND_ONE;
    end else if (!az && bz && !cz) begin
      if (a_q[CW-1] != c_q[CW-1]) begin
        ctl_o.op   = qrs_pkg::OP_SQRT;
        ctl_o.kind = qrs_pkg::KIND_TWO;
      end else begin
        ctl_o.kind = qrs_pkg::KIND_NONE;
      end
    end else if (!az && !bz && cz) begin
      ctl_o.op   = qrs_pkg::OP_CZERO;
      ctl_o.kind = qrs_pkg::KIND_TWO;
    end else if (az && bz && !cz) begin
      ctl_o.kind = qrs_pkg::KIND_NONE;
    end else if (!az || !bz) begin
      ctl_o.kind = qrs_pkg::KIND_ONE;
    end
  end

  // operands for the back end
  always_comb begin
    rad_o     = '0;
    nb_o      = '0;
    den_o     = amag;
    den_neg_o = a_q[CW-1];
    case (ctl_o.op)
      qrs_pkg::OP_QUAD: begin
        rad_o = VW'(disc);
        nb_o  = nb_b;
        den_o = amag << 1;
      end
      qrs_pkg::OP_DOUBLE: begin
        nb_o  = nb_b;
        den_o = amag << 1;
      end
      qrs_pkg::OP_CZERO: nb_o = nb_b;
      qrs_pkg::OP_LIN: begin
        nb_o      = nb_c;
        den_o     = bmag;
        den_neg_o = b_q[CW-1];
      end
      qrs_pkg::OP_SQRT: begin
        rad_o     = VW'(-ac_q);
        den_neg_o = 1'b0;
      end
      default: ;
    endcase
  end

endmodule

@@ src/qrs_sqrt_pipe.sv @@
module qrs_sqrt_pipe #(
  parameter int unsigned RAD_W = 66,
  parameter int unsigned PW    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [RAD_W-1:0]     rad_i,
  input  logic [PW-1:0]        pay_i,
  output logic                 valid_o,
  output logic [RAD_W/2-1:0]   root_o,
  output logic [PW-1:0]        pay_o
);

  localparam int unsigned N     = RAD_W / 2;
  localparam int unsigned REM_W = N + 3;

  logic             v_q    [N];
  logic [RAD_W-1:0] rad_q  [N];
  logic [REM_W-1:0] rem_q  [N];
  logic [N-1:0]     root_q [N];
  logic [PW-1:0]    pay_q  [N];

  for (genvar i = 0; i < N; i++) begin : g_st
    logic             v_in;
    logic [RAD_W-1:0] rad_in;
    logic [REM_W-1:0] rem_in, trial, cand, rem_d;
    logic [N-1:0]     root_in;
    logic [PW-1:0]    pay_in;
    logic             ge;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign pay_in  = pay_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign pay_in  = pay_q[i-1];
    end

    // one root digit per stage
    assign trial = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign cand  = REM_W'({root_in, 2'b01});
    assign ge    = (trial >= cand);
    assign rem_d = ge ? trial - cand : trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i]  <= rad_in << 2;
        rem_q[i]  <= rem_d;
        root_q[i] <= {root_in[N-2:0], ge};
        pay_q[i]  <= pay_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = root_q[N-1];
  assign pay_o   = pay_q[N-1];

endmodule

@@ src/qrs_div_pipe.sv @@
module qrs_div_pipe #(
  parameter int unsigned NW = 34,
  parameter int unsigned DW = 17,
  parameter int unsigned PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num1_i,
  input  logic [NW-1:0] num2_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [NW-1:0] quo1_o,
  output logic [NW-1:0] quo2_o,
  output logic [PW-1:0] pay_o
);

  logic          v_q    [NW];
  logic [NW-1:0] num1_q [NW];
  logic [NW-1:0] num2_q [NW];
  logic [DW-1:0] rem1_q [NW];
  logic [DW-1:0] rem2_q [NW];
  logic [NW-1:0] quo1_q [NW];
  logic [NW-1:0] quo2_q [NW];
  logic [DW-1:0] den_q  [NW];
  logic [PW-1:0] pay_q  [NW];

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic          v_in;
    logic [NW-1:0] num1_in, num2_in, quo1_in, quo2_in;
    logic [DW-1:0] rem1_in, rem2_in, den_in;
    logic [PW-1:0] pay_in;
    logic [DW:0]   t1, t2;
    logic          ge1, ge2;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign num1_in = num1_i;
      assign num2_in = num2_i;
      assign rem1_in = '0;
      assign rem2_in = '0;
      assign quo1_in = '0;
      assign quo2_in = '0;
      assign den_in  = den_i;
      assign pay_in  = pay_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign num1_in = num1_q[i-1];
      assign num2_in = num2_q[i-1];
      assign rem1_in = rem1_q[i-1];
      assign rem2_in = rem2_q[i-1];
      assign quo1_in = quo1_q[i-1];
      assign quo2_in = quo2_q[i-1];
      assign den_in  = den_q[i-1];
      assign pay_in  = pay_q[i-1];
    end

    // one quotient bit per stage, two lanes sharing the divisor
    assign t1  = {rem1_in, num1_in[NW-1]};
    assign t2  = {rem2_in, num2_in[NW-1]};
    assign ge1 = (t1 >= {1'b0, den_in});
    assign ge2 = (t2 >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num1_q[i] <= num1_in << 1;
        num2_q[i] <= num2_in << 1;
        rem1_q[i] <= ge1 ? DW'(t1 - {1'b0, den_in}) : DW'(t1);
        rem2_q[i] <= ge2 ? DW'(t2 - {1'b0, den_in}) : DW'(t2);
        quo1_q[i] <= {quo1_in[NW-2:0], ge1};
        quo2_q[i] <= {quo2_in[NW-2:0], ge2};
        den_q[i]  <= den_in;
        pay_q[i]  <= pay_in;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo1_o  = quo1_q[NW-1];
  assign quo2_o  = quo2_q[NW-1];
  assign pay_o   = pay_q[NW-1];

endmodule

@@ src/quadratic_root_solver_core.sv @@
// channel | signals                                                     | direction
// in      | in_valid_i, in_ready_o, coef_a/b/c_i                        | coefficient transaction in
// out     | out_valid_o, out_ready_i, first/second_root_o, root_kind_o  | root transaction out
//
// one transaction per cycle sustained while the output is not stalled; the path is
//   front product stage, one sqrt digit per stage, one quotient bit per stage, output reg
// rst_ni clears only valid bits and queue pointers, no clearing pass
// a stalled output freezes the back end; the two-entry queue lets the front keep taking work
module quadratic_root_solver_core #(
  parameter int unsigned COEF_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COEF_WIDTH-1:0]        coef_a_i,
  input  logic signed [COEF_WIDTH-1:0]        coef_b_i,
  input  logic signed [COEF_WIDTH-1:0]        coef_c_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [qrs_pkg::ROOT_W-1:0]   first_root_o,
  output logic signed [qrs_pkg::ROOT_W-1:0]   second_root_o,
  output logic [qrs_pkg::KIND_W-1:0]          root_kind_o
);

  localparam int unsigned CW     = COEF_WIDTH;
  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned VW     = 2 * CW + 1;        // discriminant magnitude
  localparam int unsigned SQW    = CW + F + 1;        // sqrt result bits
  localparam int unsigned RAD_W  = 2 * SQW;           // radicand incl. fraction pairs
  localparam int unsigned NSW    = CW + F + 3;        // signed numerator
  localparam int unsigned NW     = NSW - 1;           // numerator magnitude
  localparam int unsigned DW     = CW + 1;            // divisor magnitude
  localparam int unsigned CTL_W  = $bits(qrs_pkg::qrs_ctl_t);
  localparam int unsigned SPW    = CTL_W + NSW + DW + 1;
  localparam int unsigned QW     = SPW + VW;
  localparam int unsigned DPW    = CTL_W + 2;
  localparam int unsigned RW     = NW + 1;
  localparam int unsigned EW     = (RW > qrs_pkg::ROOT_W) ? RW : qrs_pkg::ROOT_W;
  localparam logic signed [EW-1:0] SAT_HI = EW'({1'b0, {(qrs_pkg::ROOT_W-1){1'b1}}});
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

  // front to queue
  logic                  push_valid, push_ready;
  qrs_pkg::qrs_ctl_t     f_ctl;
  logic [VW-1:0]         f_rad;
  logic signed [NSW-1:0] f_nb;
  logic [DW-1:0]         f_den;
  logic                  f_den_neg;
  logic [QW-1:0]         q_wdata, q_rdata;
  logic                  q_valid;

  // back end
  logic                  adv;
  logic                  s_valid;
  logic [SQW-1:0]        s_root;
  logic [SPW-1:0]        s_pay;
  qrs_pkg::qrs_ctl_t     s_ctl;
  logic signed [NSW-1:0] s_nb, s_val, n1, n2;
  logic [DW-1:0]         s_den;
  logic                  s_den_neg;
  logic [NW-1:0]         mag1, mag2;
  logic                  neg1, neg2;

  logic                  d_valid;
  logic [NW-1:0]         quo1, quo2;
  logic [DPW-1:0]        d_pay;
  qrs_pkg::qrs_ctl_t     d_ctl;
  logic signed [RW-1:0]  r1, r2, q1s, q2s;

  // output register
  logic                               out_valid_q;
  logic signed [qrs_pkg::ROOT_W-1:0]  first_q, second_q;
  qrs_pkg::qrs_kind_e                 kind_q;

  qrs_front #(
    .CW (CW),
    .F  (F),
    .VW (VW),
    .NSW(NSW),
    .DW (DW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .coef_a_i    (coef_a_i),
    .coef_b_i    (coef_b_i),
    .coef_c_i    (coef_c_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .ctl_o       (f_ctl),
    .rad_o       (f_rad),
    .nb_o        (f_nb),
    .den_o       (f_den),
    .den_neg_o   (f_den_neg)
  );

  assign q_wdata = {f_ctl, f_nb, f_den, f_den_neg, f_rad};

  qrs_fifo #(
    .W(QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (q_wdata),
    .pop_valid_o (q_valid),
    .pop_ready_i (adv),
    .pop_data_o  (q_rdata)
  );

  // whole back end moves together whenever the output slot frees up
  assign adv = !out_valid_q || out_ready_i;

  // radicand is scaled by 4^FRAC_BITS so the root carries the fraction bits
  qrs_sqrt_pipe #(
    .RAD_W(RAD_W),
    .PW   (SPW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(q_valid),
    .rad_i  (RAD_W'({q_rdata[VW-1:0], {(2*F){1'b0}}})),
    .pay_i  (q_rdata[QW-1:VW]),
    .valid_o(s_valid),
    .root_o (s_root),
    .pay_o  (s_pay)
  );

  assign s_ctl     = qrs_pkg::qrs_ctl_t'(s_pay[SPW-1 -: CTL_W]);
  assign s_nb      = s_pay[DW+NSW:DW+1];
  assign s_den     = s_pay[DW:1];
  assign s_den_neg = s_pay[0];
  assign s_val     = signed'({2'b00, s_root});

  // numerators for both quotient lanes
  always_comb begin
    n1 = '0;
    n2 = '0;
    case (s_ctl.op)
      qrs_pkg::OP_QUAD: begin
        n1 = s_nb - s_val;
        n2 = s_nb + s_val;
      end
      qrs_pkg::OP_DOUBLE, qrs_pkg::OP_CZERO, qrs_pkg::OP_LIN: n1 = s_nb;
      qrs_pkg::OP_SQRT: n1 = s_val;
      default: ;
    endcase
  end

  // sign-magnitude so the quotient truncates toward zero
  assign neg1 = n1[NSW-1] ^ s_den_neg;
  assign neg2 = n2[NSW-1] ^ s_den_neg;
  assign mag1 = n1[NSW-1] ? NW'(-n1) : NW'(n1);
  assign mag2 = n2[NSW-1] ? NW'(-n2) : NW'(n2);

  qrs_div_pipe #(
    .NW(NW),
    .DW(DW),
    .PW(DPW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(s_valid),
    .num1_i (mag1),
    .num2_i (mag2),
    .den_i  (s_den),
    .pay_i  ({s_ctl, neg1, neg2}),
    .valid_o(d_valid),
    .quo1_o (quo1),
    .quo2_o (quo2),
    .pay_o  (d_pay)
  );

  assign d_ctl = qrs_pkg::qrs_ctl_t'(d_pay[DPW-1 -: CTL_W]);
  assign q1s   = d_pay[1] ? -signed'({1'b0, quo1}) : signed'({1'b0, quo1});
  assign q2s   = d_pay[0] ? -signed'({1'b0, quo2}) : signed'({1'b0, quo2});

  // pick the roots per operation
  always_comb begin
    r1 = q1s;
    r2 = '0;
    case (d_ctl.op)
      qrs_pkg::OP_QUAD:   r2 = q2s;
      qrs_pkg::OP_DOUBLE: r2 = q1s;
      qrs_pkg::OP_SQRT:   r2 = -q1s;
      qrs_pkg::OP_ZERO:   r1 = '0;
      default: ;
    endcase
  end

  function automatic logic signed [qrs_pkg::ROOT_W-1:0] sat_root(
    input logic signed [RW-1:0] r
  );
    logic signed [EW-1:0] e;
    e = EW'(r);
    if (e > SAT_HI) e = SAT_HI;
    if (e < SAT_LO) e = SAT_LO;
    return e[qrs_pkg::ROOT_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      first_q  <= sat_root(r1);
      second_q <= sat_root(r2);
      kind_q   <= d_ctl.kind;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign first_root_o  = first_q;
  assign second_root_o = second_q;
  assign root_kind_o   = kind_q;

endmodule

@@ bench/quadratic_root_solver_core_test.sv @@
module quadratic_root_solver_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COEF_W = 16;
  localparam int unsigned FRAC_W = 16;
  // pipeline depth, used to size the long stall and the end-of-run wait
  localparam int unsigned PIPE_LAT = 2 + (COEF_W + FRAC_W + 1) + (COEF_W + FRAC_W + 2) + 1;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } coef_set_t;

  typedef struct packed {
    logic signed [qrs_pkg::ROOT_W-1:0] r1;
    logic signed [qrs_pkg::ROOT_W-1:0] r2;
    qrs_pkg::qrs_kind_e                kind;
  } root_set_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic signed [COEF_W-1:0]            coef_a_i;
  logic signed [COEF_W-1:0]            coef_b_i;
  logic signed [COEF_W-1:0]            coef_c_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic signed [qrs_pkg::ROOT_W-1:0]   first_root_o;
  logic signed [qrs_pkg::ROOT_W-1:0]   second_root_o;
  logic [qrs_pkg::KIND_W-1:0]          root_kind_o;

  quadratic_root_solver_core #(
    .COEF_WIDTH(COEF_W),
    .FRAC_BITS (FRAC_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .coef_a_i     (coef_a_i),
    .coef_b_i     (coef_b_i),
    .coef_c_i     (coef_c_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .first_root_o (first_root_o),
    .second_root_o(second_root_o),
    .root_kind_o  (root_kind_o)
  );

  coef_set_t pending_eqs[$];   // equations waiting to be driven
  root_set_t expected_roots[$]; // predicted results, oldest first
  int        error_count = 0;
  bit        stim_done = 0;
  bit        hold_off = 0;      // long receiver stall requested by the stimulus
  bit        drain_wait = 0;    // sender pause until everything has come back
  bit        in_taken = 0;      // input transaction accepted at the last rising edge

  // clock, 4 ns period
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // floor(sqrt(v)) digit by digit, 128-bit wide to cover d * 2^(2F)
  function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
    logic [127:0] rem;
    logic [127:0] root;
    logic [127:0] trial;
    rem = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  // clamp to the signed root range
  function automatic logic signed [qrs_pkg::ROOT_W-1:0] clamp_root(input longint r);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (qrs_pkg::ROOT_W - 1)) - 1;
    lo = -(longint'(1) <<< (qrs_pkg::ROOT_W - 1));
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[qrs_pkg::ROOT_W-1:0];
  endfunction

  // real roots of a*x*x + b*x + c in fixed point; sv division truncates toward zero
  function automatic root_set_t solve_quadratic(input coef_set_t eq);
    longint a;
    longint b;
    longint c;
    longint d;
    longint s;
    longint r1;
    longint r2;
    longint ua;
    longint uc;
    logic [127:0] q;
    qrs_pkg::qrs_kind_e kind;
    root_set_t res;
    a = eq.a;
    b = eq.b;
    c = eq.c;
    r1 = 0;
    r2 = 0;
    if (a != 0 && b != 0 && c != 0) begin
      d = b * b - 4 * a * c;
      if (d > 0) begin
        s = longint'(floor_sqrt(128'(d) << (2 * FRAC_W)));
        r1 = (-(b <<< FRAC_W) - s) / (2 * a);
        r2 = (-(b <<< FRAC_W) + s) / (2 * a);
        kind = qrs_pkg::KIND_TWO;
      end else if (d == 0) begin
        r1 = -(b <<< FRAC_W) / (2 * a);
        r2 = r1;
        kind = qrs_pkg::KIND_DOUBLE;
      end else begin
        kind = qrs_pkg::KIND_NONE;
      end
    end else if (a == 0 && b != 0 && c != 0) begin
      r1 = -(c <<< FRAC_W) / b;
      kind = qrs_pkg::KIND_ONE;
    end else if (a != 0 && b == 0 && c != 0) begin
      if ((a > 0) != (c > 0)) begin
        ua = (a < 0) ? -a : a;
        uc = (c < 0) ? -c : c;
        q = (128'(uc) << (2 * FRAC_W)) / 128'(ua);
        s = longint'(floor_sqrt(q));
        r1 = s;
        r2 = -s;
        kind = qrs_pkg::KIND_TWO;
      end else begin
        kind = qrs_pkg::KIND_NONE;
      end
    end else if (a != 0 && b != 0 && c == 0) begin
      r1 = -(b <<< FRAC_W) / a;
      kind = qrs_pkg::KIND_TWO;
    end else if (a == 0 && b == 0 && c != 0) begin
      kind = qrs_pkg::KIND_NONE;
    end else if (a != 0 || b != 0) begin
      kind = qrs_pkg::KIND_ONE;
    end else begin
      kind = qrs_pkg::KIND_ALL;
    end
    res.r1 = clamp_root(r1);
    res.r2 = clamp_root(r2);
    res.kind = kind;
    return res;
  endfunction

  // random coefficient, biased toward zero, small values and extremes
  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2, 3:    return $signed(16'($urandom_range(0, 20))) - 16'sd10;
      default: return 16'($urandom());
    endcase
  endfunction

  // queue an equation for the driver
  task automatic add_eq(input int a, input int b, input int c);
    coef_set_t eq;
    eq.a = a[COEF_W-1:0];
    eq.b = b[COEF_W-1:0];
    eq.c = c[COEF_W-1:0];
    pending_eqs.push_back(eq);
  endtask

  // input handshake seen at the rising edge
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
  end

  // driver: changes inputs on the falling edge, gaps of random length
  int gap_left = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      coef_a_i <= '0;
      coef_b_i <= '0;
      coef_c_i <= '0;
    end else begin
      // was the offered transaction taken at the last rising edge
      if (in_taken) begin
        expected_roots.push_back(solve_quadratic({coef_a_i, coef_b_i, coef_c_i}));
        void'(pending_eqs.pop_front());
        gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                 : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      end
      if (in_valid_i && !in_taken) begin
        // hold the offer unchanged
      end else if (gap_left > 0 || drain_wait || pending_eqs.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        coef_a_i <= pending_eqs[0].a;
        coef_b_i <= pending_eqs[0].b;
        coef_c_i <= pending_eqs[0].c;
      end
    end
  end

  // receiver backpressure, decided on the falling edge
  int stall_left = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    root_set_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected result transaction r1=%0d r2=%0d kind=%0d",
                 $time, first_root_o, second_root_o, root_kind_o);
        error_count++;
      end else begin
        want = expected_roots.pop_front();
        if (first_root_o !== want.r1) begin
          $display("%0t: first_root expected %0d actual %0d", $time, want.r1, first_root_o);
          error_count++;
        end
        if (second_root_o !== want.r2) begin
          $display("%0t: second_root expected %0d actual %0d",
                   $time, want.r2, second_root_o);
          error_count++;
        end
        if (root_kind_o !== want.kind) begin
          $display("%0t: root_kind expected %0d actual %0d", $time, want.kind, root_kind_o);
          error_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int n;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: every case and the coefficient extremes
    add_eq(1, -3, 2);            // two roots from the discriminant
    add_eq(1, 2, 1);             // double root
    add_eq(1, 1, 1);             // negative discriminant
    add_eq(0, 3, 7);             // linear
    add_eq(0, -32768, 32767);
    add_eq(1, 0, -4);            // plus or minus sqrt
    add_eq(-3, 0, 5);
    add_eq(2, 0, 5);             // same signs, no roots
    add_eq(3, 6, 0);             // -b/a and zero
    add_eq(0, 0, 9);             // constant only
    add_eq(5, 0, 0);             // root at zero
    add_eq(0, -7, 0);
    add_eq(0, 0, 0);             // all reals
    add_eq(-32768, -32768, -32768);
    add_eq(32767, 32767, 32767);
    add_eq(-32768, 32767, 32767);
    add_eq(1, -32768, -32768);
    add_eq(1, 0, -32768);
    add_eq(-32768, 0, 32767);
    add_eq(1, -32768, 0);
    add_eq(-1, 32767, 1);
    add_eq(0, 1, -32768);
    add_eq(-32768, 1, 0);
    add_eq(-1, -2, -1);
    wait (pending_eqs.size() == 0);

    // random, part one
    repeat (900) add_eq(pick_coef(), pick_coef(), pick_coef());
    wait (pending_eqs.size() < 600);

    // long receiver stall so the pipeline fills and stalls its input
    hold_off = 1'b1;
    repeat (PIPE_LAT * 3) @(posedge clk_i);
    hold_off = 1'b0;
    wait (pending_eqs.size() == 0);

    // sender pause until every result is back
    drain_wait = 1'b1;
    wait (expected_roots.size() == 0);
    drain_wait = 1'b0;

    // random, part two, with perfect squares for double roots
    n = 0;
    while (n < 1000) begin
      if ($urandom_range(0, 7) == 0) begin
        int k;
        int m;
        k = $urandom_range(1, 100);
        m = $urandom_range(1, 100);
        if ($urandom_range(0, 1)) m = -m;
        add_eq(k * k, 2 * k * m, m * m);
      end else begin
        add_eq(pick_coef(), pick_coef(), pick_coef());
      end
      n++;
    end
    wait (pending_eqs.size() == 0);
    stim_done = 1'b1;
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (expected_roots.size() == 0);
    repeat (PIPE_LAT + 20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("quadratic_root_solver_core regression: pass");
    end else begin
      $display("quadratic_root_solver_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4ms;
    $display("quadratic_root_solver_core regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
src/qrs_pkg.sv
src/qrs_fifo.sv
src/qrs_front.sv
src/qrs_sqrt_pipe.sv
src/qrs_div_pipe.sv
src/quadratic_root_solver_core.sv
bench/quadratic_root_solver_core_test.sv
